[sv/i2c_rrs_pkg.sv]
// Package of the I2C register-read sequencer: event codes, phase codes,
// configuration register indexes and the result record. No dependencies.

package i2c_rrs_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 8;

  localparam logic [OpW-1:0] OP_START = 3'd0;
  localparam logic [OpW-1:0] OP_ACK   = 3'd1;
  localparam logic [OpW-1:0] OP_NACK  = 3'd2;
  localparam logic [OpW-1:0] OP_RX    = 3'd3;
  localparam logic [OpW-1:0] OP_MSTOP = 3'd4;

  localparam logic [PhaseW-1:0] PH_IDLE     = 3'd0;
  localparam logic [PhaseW-1:0] PH_ADDR_W   = 3'd1;
  localparam logic [PhaseW-1:0] PH_REG      = 3'd2;
  localparam logic [PhaseW-1:0] PH_ADDR_R   = 3'd3;
  localparam logic [PhaseW-1:0] PH_HIGH     = 3'd4;
  localparam logic [PhaseW-1:0] PH_LOW      = 3'd5;
  localparam logic [PhaseW-1:0] PH_STOPPING = 3'd6;

  localparam logic [CfgIdxW-1:0] REG_DEVICE_ADDRESS   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_REGISTER_ADDRESS = 1'd1;

  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  typedef struct packed {
    logic        issue_start;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        issue_ack;
    logic        issue_nack;
    logic        issue_stop;
    logic        done_res;
    logic [15:0] read_value;
    logic        protocol_error;
  } res_t;

endpackage

[sv/i2c_rrs_if.sv]
// Handshake interfaces of the I2C register-read sequencer: bus events in,
// command results out, and the configuration write channel. Uses i2c_rrs_pkg.

interface i2c_rrs_in_if import i2c_rrs_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OpW-1:0] op;
  logic [7:0]     rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface i2c_rrs_res_if;
  logic        valid;
  logic        ready;
  logic        issue_start;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        issue_ack;
  logic        issue_nack;
  logic        issue_stop;
  logic        done_res;
  logic [15:0] read_value;
  logic        protocol_error;

  modport source (
    output valid, output issue_start, output tx_valid, output tx_byte,
    output issue_ack, output issue_nack, output issue_stop, output done_res,
    output read_value, output protocol_error, input ready
  );
  modport sink (
    input valid, input issue_start, input tx_valid, input tx_byte,
    input issue_ack, input issue_nack, input issue_stop, input done_res,
    input read_value, input protocol_error, output ready
  );
endinterface

interface i2c_rrs_cfg_if import i2c_rrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/i2c_register_read_sequencer_top.sv]
// The sequencer accepts one bus event per clock cycle and presents its command
// result in the next cycle from a result register; in_i.ready is low only while
// that register holds a result the consumer has not yet taken, so with a ready
// consumer the rate is one transaction per cycle. The phase and the assembled
// value update at the event's acceptance, so the following event may arrive in
// the very next cycle. The configuration channel is always ready; a new device
// or register address is used from the next transmitted byte. Depends on
// i2c_rrs_pkg and the interfaces in i2c_rrs_if.

module i2c_register_read_sequencer_top import i2c_rrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2c_rrs_in_if.sink         in_i,
  i2c_rrs_res_if.source      res_o,
  i2c_rrs_cfg_if.sink        cfg_i
);

  logic [6:0]        dev_addr_q;
  logic [7:0]        reg_addr_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [15:0]       held_q, held_d;
  logic              res_valid_q;
  res_t              res_q, res_d;
  logic              in_acc;
  logic              res_acc;

  assign in_i.ready  = !res_valid_q || res_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign res_acc     = res_valid_q && res_o.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
      reg_addr_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEVICE_ADDRESS:   dev_addr_q <= cfg_i.data[6:0];
        REG_REGISTER_ADDRESS: reg_addr_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    res_d   = '0;
    case (phase_q)
      PH_IDLE: begin
        if (in_i.op == OP_START) begin
          res_d.issue_start = 1'b1;
          res_d.tx_valid    = 1'b1;
          res_d.tx_byte     = {dev_addr_q, RW_WRITE};
          phase_d           = PH_ADDR_W;
        end else begin
          res_d.protocol_error = 1'b1;
        end
      end
      PH_ADDR_W: begin
        if (in_i.op == OP_ACK) begin
          res_d.tx_valid = 1'b1;
          res_d.tx_byte  = reg_addr_q;
          phase_d        = PH_REG;
        end else begin
          res_d.protocol_error = 1'b1;
        end
      end
      PH_REG: begin
        if (in_i.op == OP_ACK) begin
          res_d.issue_start = 1'b1;
          res_d.tx_valid    = 1'b1;
          res_d.tx_byte     = {dev_addr_q, RW_READ};
          phase_d           = PH_ADDR_R;
        end else begin
          res_d.protocol_error = 1'b1;
        end
      end
      PH_ADDR_R: begin
        if (in_i.op == OP_NACK) begin
          res_d.issue_start = 1'b1;
          res_d.tx_valid    = 1'b1;
          res_d.tx_byte     = {dev_addr_q, RW_READ};
        end else if (in_i.op == OP_ACK) begin
          phase_d = PH_HIGH;
        end else begin
          res_d.protocol_error = 1'b1;
        end
      end
      PH_HIGH: begin
        if (in_i.op == OP_RX) begin
          held_d          = {in_i.rx_byte, 8'h00};
          res_d.issue_ack = 1'b1;
          phase_d         = PH_LOW;
        end else begin
          res_d.protocol_error = 1'b1;
        end
      end
      PH_LOW: begin
        if (in_i.op == OP_RX) begin
          held_d           = held_q | {8'h00, in_i.rx_byte};
          res_d.issue_nack = 1'b1;
          res_d.issue_stop = 1'b1;
          phase_d          = PH_STOPPING;
        end else begin
          res_d.protocol_error = 1'b1;
        end
      end
      PH_STOPPING: begin
        if (in_i.op == OP_MSTOP) begin
          res_d.done_res   = 1'b1;
          res_d.read_value = held_q;
          phase_d          = PH_IDLE;
        end else begin
          res_d.protocol_error = 1'b1;
        end
      end
      default: begin
        res_d.protocol_error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      held_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        held_q      <= held_d;
        res_valid_q <= 1'b1;
      end else if (res_acc) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.issue_start    = res_q.issue_start;
  assign res_o.tx_valid       = res_q.tx_valid;
  assign res_o.tx_byte        = res_q.tx_byte;
  assign res_o.issue_ack      = res_q.issue_ack;
  assign res_o.issue_nack     = res_q.issue_nack;
  assign res_o.issue_stop     = res_q.issue_stop;
  assign res_o.done_res       = res_q.done_res;
  assign res_o.read_value     = res_q.read_value;
  assign res_o.protocol_error = res_q.protocol_error;

endmodule

[sv/i2c_rrs_checker.sv]
// Port-level checker of the I2C register-read sequencer and its bind to the
// top level. Imports i2c_rrs_pkg but takes no widths from it.

module i2c_rrs_checker import i2c_rrs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        issue_start_i,
  input logic        tx_valid_i,
  input logic [7:0]  tx_byte_i,
  input logic        issue_ack_i,
  input logic        issue_nack_i,
  input logic        issue_stop_i,
  input logic        done_res_i,
  input logic [15:0] read_value_i,
  input logic        protocol_error_i
);

  // A stalled result stays valid and holds its value, byte and error flag until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(read_value_i)
      && $stable(tx_byte_i) && $stable(protocol_error_i))
    else $error("stalled result changed");

  // A rejected event commands nothing on the bus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && protocol_error_i |-> !issue_start_i && !tx_valid_i
      && !issue_ack_i && !issue_nack_i && !issue_stop_i && !done_res_i)
    else $error("error result carries a command");

  // Unused payload fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (!tx_valid_i && tx_byte_i != 8'h00
      || !done_res_i && read_value_i != 16'h0000) |-> 1'b0)
    else $error("unused result field not zero");

  // Each accepted event yields a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> res_valid_i)
    else $error("accepted event produced no result");

endmodule

bind i2c_register_read_sequencer_top i2c_rrs_checker u_i2c_rrs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .issue_start_i    (res_o.issue_start),
  .tx_valid_i       (res_o.tx_valid),
  .tx_byte_i        (res_o.tx_byte),
  .issue_ack_i      (res_o.issue_ack),
  .issue_nack_i     (res_o.issue_nack),
  .issue_stop_i     (res_o.issue_stop),
  .done_res_i       (res_o.done_res),
  .read_value_i     (res_o.read_value),
  .protocol_error_i (res_o.protocol_error)
);
